[sv/jtq_pkg.sv]
// Shared types, codes and constants of the transmit schedule queue.
`timescale 1ns / 1ps
`default_nettype none
package jtq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int TAG_BITS    = 16;
	localparam int CFG_IDX_W   = 3;

	typedef logic [31:0]          us_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [FILL_W-1:0]    fill_t;
	typedef logic [TAG_BITS-1:0]  tag_t;

	typedef enum logic [1:0] {
		FN_ENQ  = 2'd0,
		FN_DEQ  = 2'd1,
		FN_PEEK = 2'd2,
		FN_BAD  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_A   = 2'd0,
		KIND_B   = 2'd1,
		KIND_C   = 2'd2,
		KIND_BCN = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_LATE     = 3'd2,
		ST_EARLY    = 3'd3,
		ST_PKT_COLL = 3'd4,
		ST_BCN_COLL = 3'd5,
		ST_EMPTY    = 3'd6,
		ST_INVALID  = 3'd7
	} status_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROG_DELAY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADVANCE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BCN_GUARD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BCN_RESERVE = 3'd5;

	localparam us_t RST_START_DELAY = 32'd1500;
	localparam us_t RST_MARGIN      = 32'd1000;
	localparam us_t RST_PROG_DELAY  = 32'd40000;
	localparam us_t RST_MAX_ADVANCE = 32'd512000000;
	localparam us_t RST_BCN_GUARD   = 32'd3000000;
	localparam us_t RST_BCN_RESERVE = 32'd2120000;
	localparam us_t US_PER_MS       = 32'd1000;

	// scan index operations
	typedef enum logic [2:0] {
		K_HOLD = 3'd0,
		K_ZERO = 3'd1,
		K_INC  = 3'd2,
		K_IDX  = 3'd3,
		K_LAST = 3'd4,
		K_R1   = 3'd5,
		K_R    = 3'd6
	} kop_t;

	typedef struct packed {
		us_t        t;
		us_t        pre;
		us_t        post;
		logic [1:0] kind;
		tag_t       tag;
	} entry_t;

	typedef struct packed {
		logic [1:0]  func;
		us_t         now_us;
		logic [1:0]  pkt_kind;
		us_t         target_us;
		logic [15:0] air_time_ms;
		logic [15:0] packet_tag;
		logic [4:0]  entry_index;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  found_index;
		us_t         slot_us;
		logic [1:0]  out_kind;
		logic [15:0] out_tag;
		logic [5:0]  occupancy;
	} out_word_t;

	typedef struct packed {
		logic    latch;
		logic    setup;
		kop_t    k_op;
		logic    rd;
		logic    cand;
		logic    save_last;
		logic    set_r;
		logic    set_p;
		logic    best_upd;
		logic    res_deq;
		logic    res_enq;
		logic    res_found;
		logic    set_status;
		status_t status_code;
		logic    publish;
		logic    insert;
		logic    shift_rm;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  fill_zero;
		logic  full;
		logic  idx_bad;
		logic  is_c;
		logic  k_end;
		logic  k_last;
		logic  k_is0;
		logic  coll_new;
		logic  coll_chk;
		logic  coll_bcn;
		logic  late;
		logic  early;
		logic  gt;
		logic  eq_last;
		logic  stale;
		logic  better;
		logic  due;
	} sts_t;

endpackage
`default_nettype wire

[sv/jtq_in_if.sv]
// Request channel carrying one queue operation word.
`timescale 1ns / 1ps
`default_nettype none
interface jtq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] now_us;
	logic [1:0]  pkt_kind;
	logic [31:0] target_us;
	logic [15:0] air_time_ms;
	logic [15:0] packet_tag;
	logic [4:0]  entry_index;

	modport source (output valid, func, now_us, pkt_kind, target_us, air_time_ms,
		packet_tag, entry_index, input ready);
	modport sink (input valid, func, now_us, pkt_kind, target_us, air_time_ms,
		packet_tag, entry_index, output ready);
endinterface
`default_nettype wire

[sv/jtq_out_if.sv]
// Response channel carrying one queue result word.
`timescale 1ns / 1ps
`default_nettype none
interface jtq_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [4:0]  found_index;
	logic [31:0] slot_us;
	logic [1:0]  out_kind;
	logic [15:0] out_tag;
	logic [5:0]  occupancy;

	modport source (output valid, status, found_index, slot_us, out_kind, out_tag,
		occupancy, input ready);
	modport sink (input valid, status, found_index, slot_us, out_kind, out_tag,
		occupancy, output ready);
endinterface
`default_nettype wire

[sv/jtq_cfg_if.sv]
// Configuration write channel: register index and data.
`timescale 1ns / 1ps
`default_nettype none
interface jtq_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/jtq_datapath.sv]
// Datapath: entry table, config registers, scan unit and result registers.
`timescale 1ns / 1ps
`default_nettype none
module jtq_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  jtq_pkg::cmd_t                        cmd,
	output jtq_pkg::sts_t                        sts,
	input  jtq_pkg::in_word_t                    in_word,
	input  logic                                 cfg_we,
	input  logic [jtq_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [31:0]                          cfg_data,
	output jtq_pkg::out_word_t                   out_word
);
	import jtq_pkg::*;

	us_t sd_q, margin_q, pd_q, maxadv_q, bg_q, br_q;

	entry_t ent_q [QUEUE_DEPTH];
	fill_t  fill_q;

	func_t      func_q;
	logic [1:0] kind_q;
	us_t        now_q, stamp_q, pre_q, post_q;
	tag_t       tag_q;
	idx_t       idx_q;
	us_t        km_q, kp_q, kc_q, lim_q;

	fill_t  k_q;
	idx_t   r_q, p_q, best_q;
	us_t    best_d_q;
	entry_t cur_q, last_q;

	status_t    res_status_q;
	idx_t       res_found_q;
	us_t        res_slot_q;
	logic [1:0] res_kind_q;
	tag_t       res_tag_q;
	out_word_t  o_q;

	us_t  d_new, d_old, d_ns, d_cur, tpre;
	logic is_bcn_in;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_q     <= RST_START_DELAY;
			margin_q <= RST_MARGIN;
			pd_q     <= RST_PROG_DELAY;
			maxadv_q <= RST_MAX_ADVANCE;
			bg_q     <= RST_BCN_GUARD;
			br_q     <= RST_BCN_RESERVE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_START_DELAY: sd_q     <= cfg_data;
				CFG_MARGIN:      margin_q <= cfg_data;
				CFG_PROG_DELAY:  pd_q     <= cfg_data;
				CFG_MAX_ADVANCE: maxadv_q <= cfg_data;
				CFG_BCN_GUARD:   bg_q     <= cfg_data;
				CFG_BCN_RESERVE: br_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// evaluation of the entry held in cur_q
	assign d_new = stamp_q - cur_q.t;
	assign d_old = cur_q.t - stamp_q;
	assign d_ns  = stamp_q - now_q;
	assign d_cur = cur_q.t - now_q;
	// class A and C see only the start delay ahead of a beacon
	assign tpre  = ((kind_q == KIND_A || kind_q == KIND_C) && cur_q.kind == KIND_BCN) ?
		sd_q : cur_q.pre;
	assign is_bcn_in = (in_word.pkt_kind == KIND_BCN);

	always_comb begin
		sts.func      = func_q;
		sts.fill_zero = (fill_q == '0);
		sts.full      = (fill_q == fill_t'(QUEUE_DEPTH));
		sts.idx_bad   = ({1'b0, idx_q} >= fill_q);
		sts.is_c      = (kind_q == KIND_C);
		sts.k_end     = (k_q == fill_q);
		sts.k_last    = ((k_q + fill_t'(1)) == fill_q);
		sts.k_is0     = (k_q == '0);
		sts.coll_new  = (d_new <= km_q + cur_q.post) || (d_old <= cur_q.pre + kp_q);
		sts.coll_chk  = (d_new <= km_q + cur_q.post) || (d_old <= tpre + kp_q);
		sts.coll_bcn  = (cur_q.kind == KIND_BCN);
		sts.late      = (d_ns <= lim_q);
		sts.early     = (kind_q == KIND_A || kind_q == KIND_B) && (d_ns > maxadv_q);
		sts.gt        = (cur_q.t > stamp_q);
		sts.eq_last   = (cur_q.t == last_q.t);
		sts.stale     = (d_cur >= maxadv_q);
		sts.better    = (d_cur < best_d_q);
		sts.due       = (best_d_q < pd_q);
	end

	// operation registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q  <= func_t'(in_word.func);
			kind_q  <= in_word.pkt_kind;
			now_q   <= in_word.now_us;
			tag_q   <= in_word.packet_tag[TAG_BITS-1:0];
			idx_q   <= in_word.entry_index[IDX_W-1:0];
			stamp_q <= (in_word.pkt_kind == KIND_C) ?
				in_word.now_us + {pd_q[30:0], 1'b0} : in_word.target_us;
			pre_q   <= sd_q + pd_q + (is_bcn_in ? bg_q : '0);
			post_q  <= is_bcn_in ? br_q : us_t'(in_word.air_time_ms) * US_PER_MS;
		end else if (cmd.cand) begin
			stamp_q <= cur_q.t + cur_q.post + kc_q;
		end
		if (cmd.setup) begin
			km_q  <= pre_q + margin_q;
			kp_q  <= post_q + margin_q;
			kc_q  <= pre_q + pd_q + margin_q;
			lim_q <= sd_q + margin_q + pd_q;
		end
		if (cmd.rd)
			cur_q <= ent_q[k_q[IDX_W-1:0]];
		if (cmd.save_last)
			last_q <= cur_q;
		if (cmd.set_r)
			r_q <= k_q[IDX_W-1:0];
		if (cmd.set_p)
			p_q <= idx_t'(k_q - fill_t'(1));
		if (cmd.best_upd) begin
			best_q   <= k_q[IDX_W-1:0];
			best_d_q <= d_cur;
		end
	end

	// scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else begin
			case (cmd.k_op)
				K_ZERO:  k_q <= '0;
				K_INC:   k_q <= k_q + fill_t'(1);
				K_IDX:   k_q <= {1'b0, idx_q};
				K_LAST:  k_q <= fill_q - fill_t'(1);
				K_R1:    k_q <= {1'b0, r_q} + fill_t'(1);
				K_R:     k_q <= {1'b0, r_q};
				default: k_q <= k_q;
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			res_status_q <= ST_OK;
			res_found_q  <= '0;
			res_slot_q   <= '0;
			res_kind_q   <= '0;
			res_tag_q    <= '0;
		end else begin
			if (cmd.set_status)
				res_status_q <= cmd.status_code;
			if (cmd.res_found)
				res_found_q <= best_q;
			if (cmd.res_enq)
				res_slot_q <= stamp_q;
			if (cmd.res_deq) begin
				res_slot_q <= cur_q.t;
				res_kind_q <= cur_q.kind;
				res_tag_q  <= cur_q.tag;
			end
		end
		if (cmd.publish) begin
			o_q.status      <= res_status_q;
			o_q.found_index <= 5'(res_found_q);
			o_q.slot_us     <= res_slot_q;
			o_q.out_kind    <= res_kind_q;
			o_q.out_tag     <= 16'(res_tag_q);
			o_q.occupancy   <= 6'(fill_q);
		end
	end

	assign out_word = o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (cmd.insert)
			fill_q <= fill_q + fill_t'(1);
		else if (cmd.shift_rm)
			fill_q <= fill_q - fill_t'(1);
	end

	// entry table: each row loads a neighbour, the new entry or the saved last entry
	for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_row
		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				if (fill_t'(j) == k_q)
					ent_q[j] <= '{t: stamp_q, pre: pre_q, post: post_q, kind: kind_q,
						tag: tag_q};
				else if (fill_t'(j) > k_q)
					ent_q[j] <= ent_q[(j == 0) ? 0 : j - 1];
			end else if (cmd.shift_rm) begin
				if (idx_t'(j) >= r_q && idx_t'(j) < p_q)
					ent_q[j] <= ent_q[(j == QUEUE_DEPTH - 1) ? j : j + 1];
				else if (idx_t'(j) == p_q)
					ent_q[j] <= last_q;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= fill_t'(QUEUE_DEPTH))
		else $error("occupancy beyond table depth");
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> k_q < fill_q)
		else $error("scan read of an unoccupied row");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> fill_q == $past(fill_q) + fill_t'(1))
		else $error("insert did not grow occupancy");
	a_remove_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_rm |-> p_q >= r_q)
		else $error("removal target ahead of removed row");
`endif
endmodule
`default_nettype wire

[sv/jtq_ctrl.sv]
// Controller state machine sequencing the scans of each queue operation.
`timescale 1ns / 1ps
`default_nettype none
module jtq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output jtq_pkg::cmd_t cmd,
	input  jtq_pkg::sts_t sts
);
	import jtq_pkg::*;

	typedef enum logic [28:0] {
		S_IDLE    = 29'd1 << 0,
		S_SETUP   = 29'd1 << 1,
		S_C1_RD   = 29'd1 << 2,
		S_C1_EV   = 29'd1 << 3,
		S_C2_RD   = 29'd1 << 4,
		S_C2_CAND = 29'd1 << 5,
		S_C2_RD2  = 29'd1 << 6,
		S_C2_EV   = 29'd1 << 7,
		S_CHK     = 29'd1 << 8,
		S_K_RD    = 29'd1 << 9,
		S_K_EV    = 29'd1 << 10,
		S_Q_RD    = 29'd1 << 11,
		S_Q_EV    = 29'd1 << 12,
		S_INS     = 29'd1 << 13,
		S_D_RD    = 29'd1 << 14,
		S_D_CAP   = 29'd1 << 15,
		S_R_LRD   = 29'd1 << 16,
		S_R_LSV   = 29'd1 << 17,
		S_R_CHK   = 29'd1 << 18,
		S_R_RD    = 29'd1 << 19,
		S_R_EV    = 29'd1 << 20,
		S_R_SH    = 29'd1 << 21,
		S_S_CHK   = 29'd1 << 22,
		S_S_RD    = 29'd1 << 23,
		S_S_EV    = 29'd1 << 24,
		S_B_RD    = 29'd1 << 25,
		S_B_EV    = 29'd1 << 26,
		S_B_FIN   = 29'd1 << 27,
		S_DONE    = 29'd1 << 28
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup      = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status_code = ST_OK;
				unique case (sts.func)
					FN_ENQ: begin
						cmd.k_op = K_ZERO;
						if (sts.full) begin
							cmd.status_code = ST_FULL;
							state_d = S_DONE;
						end else if (sts.is_c && !sts.fill_zero)
							state_d = S_C1_RD;
						else
							state_d = S_CHK;
					end
					FN_DEQ: begin
						if (sts.fill_zero) begin
							cmd.status_code = ST_EMPTY;
							state_d = S_DONE;
						end else if (sts.idx_bad) begin
							cmd.status_code = ST_INVALID;
							state_d = S_DONE;
						end else begin
							cmd.k_op = K_IDX;
							state_d  = S_D_RD;
						end
					end
					FN_PEEK: begin
						if (sts.fill_zero) begin
							cmd.status_code = ST_EMPTY;
							state_d = S_DONE;
						end else begin
							cmd.k_op = K_ZERO;
							state_d  = S_S_RD;
						end
					end
					default: begin
						cmd.status_code = ST_INVALID;
						state_d = S_DONE;
					end
				endcase
			end
			// class C: does the earliest stamp clear every entry?
			S_C1_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_C1_EV;
			end
			S_C1_EV: begin
				if (sts.coll_new) begin
					cmd.k_op = K_ZERO;
					state_d  = S_C2_RD;
				end else if (sts.k_last)
					state_d = S_CHK;
				else begin
					cmd.k_op = K_INC;
					state_d  = S_C1_RD;
				end
			end
			// class C: try the gap after each entry in turn
			S_C2_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_C2_CAND;
			end
			S_C2_CAND: begin
				cmd.cand = 1'b1;
				if (sts.k_last)
					state_d = S_CHK;
				else begin
					cmd.k_op = K_INC;
					state_d  = S_C2_RD2;
				end
			end
			S_C2_RD2: begin
				cmd.rd  = 1'b1;
				state_d = S_C2_EV;
			end
			S_C2_EV: begin
				state_d = sts.coll_new ? S_C2_CAND : S_CHK;
			end
			S_CHK: begin
				cmd.k_op = K_ZERO;
				if (sts.late) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_LATE;
					state_d = S_DONE;
				end else if (sts.early) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_EARLY;
					state_d = S_DONE;
				end else if (sts.fill_zero)
					state_d = S_INS;
				else
					state_d = S_K_RD;
			end
			S_K_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_K_EV;
			end
			S_K_EV: begin
				if (sts.coll_chk) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = sts.coll_bcn ? ST_BCN_COLL : ST_PKT_COLL;
					state_d = S_DONE;
				end else if (sts.k_last) begin
					cmd.k_op = K_ZERO;
					state_d  = S_Q_RD;
				end else begin
					cmd.k_op = K_INC;
					state_d  = S_K_RD;
				end
			end
			// insertion point: first entry later than the stamp
			S_Q_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_Q_EV;
			end
			S_Q_EV: begin
				if (sts.gt)
					state_d = S_INS;
				else begin
					cmd.k_op = K_INC;
					state_d  = sts.k_last ? S_INS : S_Q_RD;
				end
			end
			S_INS: begin
				cmd.insert      = 1'b1;
				cmd.res_enq     = 1'b1;
				cmd.set_status  = 1'b1;
				cmd.status_code = ST_OK;
				state_d = S_DONE;
			end
			S_D_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_D_CAP;
			end
			S_D_CAP: begin
				cmd.res_deq = 1'b1;
				cmd.set_r   = 1'b1;
				cmd.k_op    = K_LAST;
				state_d     = S_R_LRD;
			end
			// removal: last entry fills the hole, placed ahead of its equal-time peers
			S_R_LRD: begin
				cmd.rd  = 1'b1;
				state_d = S_R_LSV;
			end
			S_R_LSV: begin
				cmd.save_last = 1'b1;
				cmd.k_op      = K_R1;
				state_d       = S_R_CHK;
			end
			S_R_CHK: begin
				if (sts.k_end) begin
					cmd.set_p = 1'b1;
					state_d   = S_R_SH;
				end else
					state_d = S_R_RD;
			end
			S_R_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_R_EV;
			end
			S_R_EV: begin
				if (sts.eq_last) begin
					cmd.set_p = 1'b1;
					state_d   = S_R_SH;
				end else begin
					cmd.k_op = K_INC;
					state_d  = S_R_CHK;
				end
			end
			S_R_SH: begin
				cmd.shift_rm = 1'b1;
				if (sts.func == FN_PEEK) begin
					cmd.k_op = K_R;
					state_d  = S_S_CHK;
				end else begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_OK;
					state_d = S_DONE;
				end
			end
			// peek: drop stale entries, lowest first
			S_S_CHK: begin
				if (sts.k_end) begin
					if (sts.fill_zero) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_EMPTY;
						state_d = S_DONE;
					end else begin
						cmd.k_op = K_ZERO;
						state_d  = S_B_RD;
					end
				end else
					state_d = S_S_RD;
			end
			S_S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_S_EV;
			end
			S_S_EV: begin
				if (sts.stale) begin
					cmd.set_r = 1'b1;
					cmd.k_op  = K_LAST;
					state_d   = S_R_LRD;
				end else begin
					cmd.k_op = K_INC;
					state_d  = S_S_CHK;
				end
			end
			// peek: soonest entry, lowest index on ties
			S_B_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_B_EV;
			end
			S_B_EV: begin
				cmd.best_upd = sts.k_is0 || sts.better;
				if (sts.k_last)
					state_d = S_B_FIN;
				else begin
					cmd.k_op = K_INC;
					state_d  = S_B_RD;
				end
			end
			S_B_FIN: begin
				cmd.set_status  = 1'b1;
				cmd.res_found   = sts.due;
				cmd.status_code = sts.due ? ST_OK : ST_EARLY;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("result word overwritten before it was taken");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_SETUP)
		else $error("accepted word did not start an operation");
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q)
		else $error("published word not presented");
`endif
endmodule
`default_nettype wire

[sv/jit_tx_schedule_queue.sv]
// Top level of the just-in-time transmit schedule queue.
//
// Holds up to 32 pending downlink transmissions sorted by timestamp.
// Channels: req takes one operation word (enqueue, dequeue or peek),
// rsp returns exactly one result word per request, cfg writes the six
// timing registers (index 0..5, other indexes are ignored); cfg is always
// ready and must only be written while no operation is in flight.
// The block handles one request word at a time. Every scan step reads one
// table row through the single row read port.
// req.ready is high only while the controller is idle. The finished
// result sits in an output register; a new request is taken while it
// waits, but the next result is not published until rsp takes the old one,
// so a stalled receiver holds the block in its final state.
// Reset empties the queue and loads the default timing values; table
// contents are left undefined as only occupied rows are ever read.
`timescale 1ns / 1ps
`default_nettype none
module jit_tx_schedule_queue (
	input  logic      clk,
	input  logic      arst_n,
	jtq_in_if.sink    req,
	jtq_out_if.source rsp,
	jtq_cfg_if.sink   cfg
);
	import jtq_pkg::*;

	cmd_t      cmd;
	sts_t      sts;
	in_word_t  in_word;
	out_word_t out_word;

	// config port never stalls
	assign cfg.ready = 1'b1;

	assign in_word.func        = req.func;
	assign in_word.now_us      = req.now_us;
	assign in_word.pkt_kind    = req.pkt_kind;
	assign in_word.target_us   = req.target_us;
	assign in_word.air_time_ms = req.air_time_ms;
	assign in_word.packet_tag  = req.packet_tag;
	assign in_word.entry_index = req.entry_index;

	jtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	jtq_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_word  (in_word),
		.cfg_we   (cfg.valid),
		.cfg_idx  (cfg.index),
		.cfg_data (cfg.data),
		.out_word (out_word)
	);

	assign rsp.status      = out_word.status;
	assign rsp.found_index = out_word.found_index;
	assign rsp.slot_us     = out_word.slot_us;
	assign rsp.out_kind    = out_word.out_kind;
	assign rsp.out_tag     = out_word.out_tag;
	assign rsp.occupancy   = out_word.occupancy;
endmodule
`default_nettype wire

[test/jtq_sched_checker.sv]
// Watches the queue channels, predicts every result word and compares it.
`timescale 1ns / 1ps
`default_nettype none
module jtq_sched_checker (
	input  logic clk,
	input  logic arst_n,
	jtq_in_if    req,
	jtq_out_if   rsp,
	jtq_cfg_if   cfg,
	output int   fail_cnt,
	output int   pending,
	output int   word_cnt,
	output int   ok_cnt
);
	import jtq_pkg::*;

	// timing registers as last written
	us_t start_dly, margin, prog_dly, max_adv, bcn_guard, bcn_rsv;

	// mirror of the schedule table, sorted by timestamp
	us_t        row_t    [QUEUE_DEPTH];
	us_t        row_pre  [QUEUE_DEPTH];
	us_t        row_post [QUEUE_DEPTH];
	logic [1:0] row_kind [QUEUE_DEPTH];
	tag_t       row_tag  [QUEUE_DEPTH];
	int         rows;

	out_word_t due_words[$];

	function automatic bit overlaps(us_t t1, us_t p1, us_t q1, us_t t2, us_t p2, us_t q2);
		us_t d1, d2, s1, s2;
		d1 = t1 - t2;
		s1 = p1 + q2 + margin;
		d2 = t2 - t1;
		s2 = p2 + q1 + margin;
		return (d1 <= s1) || (d2 <= s2);
	endfunction

	// stable insertion sort over the occupied rows
	function automatic void sort_rows();
		int i, j;
		us_t t, a, b;
		logic [1:0] k;
		tag_t g;
		for (i = 1; i < rows; i++) begin
			t = row_t[i]; a = row_pre[i]; b = row_post[i]; k = row_kind[i]; g = row_tag[i];
			j = i;
			while (j > 0 && row_t[j-1] > t) begin
				row_t[j] = row_t[j-1]; row_pre[j] = row_pre[j-1];
				row_post[j] = row_post[j-1]; row_kind[j] = row_kind[j-1];
				row_tag[j] = row_tag[j-1];
				j--;
			end
			row_t[j] = t; row_pre[j] = a; row_post[j] = b; row_kind[j] = k; row_tag[j] = g;
		end
	endfunction

	// last row fills the hole, then re-sort
	function automatic void drop_row(int idx);
		rows--;
		row_t[idx] = row_t[rows]; row_pre[idx] = row_pre[rows];
		row_post[idx] = row_post[rows]; row_kind[idx] = row_kind[rows];
		row_tag[idx] = row_tag[rows];
		sort_rows();
	endfunction

	function automatic status_t schedule(in_word_t w, output us_t given);
		us_t now, stamp, pre, post, tpre, lead;
		int i;
		now = w.now_us;
		stamp = w.target_us;
		given = '0;
		if (rows >= QUEUE_DEPTH)
			return ST_FULL;
		if (w.pkt_kind == KIND_BCN) begin
			pre = start_dly + bcn_guard + prog_dly;
			post = bcn_rsv;
		end else begin
			pre = start_dly + prog_dly;
			post = us_t'(w.air_time_ms) * US_PER_MS;
		end
		if (w.pkt_kind == KIND_C) begin
			// earliest free gap: try the nominal time, then after each row
			stamp = now + (prog_dly << 1);
			for (i = 0; i < rows; i++)
				if (overlaps(stamp, pre, post, row_t[i], row_pre[i], row_post[i]))
					break;
			if (i < rows) begin
				for (i = 0; i < rows; i++) begin
					stamp = row_t[i] + row_post[i] + pre + prog_dly + margin;
					if (i + 1 < rows && !overlaps(stamp, pre, post, row_t[i+1],
							row_pre[i+1], row_post[i+1]))
						break;
				end
			end
		end
		lead = start_dly + margin + prog_dly;
		if (us_t'(stamp - now) <= lead)
			return ST_LATE;
		if ((w.pkt_kind == KIND_A || w.pkt_kind == KIND_B) && us_t'(stamp - now) > max_adv)
			return ST_EARLY;
		for (i = 0; i < rows; i++) begin
			if ((w.pkt_kind == KIND_A || w.pkt_kind == KIND_C) && row_kind[i] == KIND_BCN)
				tpre = start_dly;
			else
				tpre = row_pre[i];
			if (overlaps(stamp, pre, post, row_t[i], tpre, row_post[i]))
				return (row_kind[i] == KIND_BCN) ? ST_BCN_COLL : ST_PKT_COLL;
		end
		row_t[rows] = stamp; row_pre[rows] = pre; row_post[rows] = post;
		row_kind[rows] = w.pkt_kind; row_tag[rows] = w.packet_tag;
		rows++;
		sort_rows();
		given = stamp;
		return ST_OK;
	endfunction

	function automatic out_word_t predict(in_word_t w);
		out_word_t o;
		us_t s;
		int i, best;
		bit any;
		o = '0;
		o.status = ST_INVALID;
		if (w.func == FN_ENQ) begin
			o.status = schedule(w, s);
			o.slot_us = s;
		end else if (w.func == FN_DEQ) begin
			if (int'(w.entry_index) >= QUEUE_DEPTH)
				o.status = ST_INVALID;
			else if (rows == 0)
				o.status = ST_EMPTY;
			else if (int'(w.entry_index) >= rows)
				o.status = ST_INVALID;
			else begin
				o.slot_us = row_t[w.entry_index];
				o.out_kind = row_kind[w.entry_index];
				o.out_tag = row_tag[w.entry_index];
				drop_row(int'(w.entry_index));
				o.status = ST_OK;
			end
		end else if (w.func == FN_PEEK) begin
			if (rows == 0)
				o.status = ST_EMPTY;
			else begin
				// stale rows go first, lowest index each time
				any = 1'b1;
				while (any) begin
					any = 1'b0;
					for (i = 0; i < rows; i++)
						if (us_t'(row_t[i] - w.now_us) >= max_adv) begin
							drop_row(i);
							any = 1'b1;
							break;
						end
				end
				if (rows == 0)
					o.status = ST_EMPTY;
				else begin
					best = 0;
					for (i = 1; i < rows; i++)
						if (us_t'(row_t[i] - w.now_us) < us_t'(row_t[best] - w.now_us))
							best = i;
					if (us_t'(row_t[best] - w.now_us) < prog_dly) begin
						o.status = ST_OK;
						o.found_index = 5'(best);
					end else
						o.status = ST_EARLY;
				end
			end
		end
		o.occupancy = 6'(rows);
		return o;
	endfunction

	function automatic void complain(string what, out_word_t e, out_word_t a);
		fail_cnt++;
		if (fail_cnt <= 10) begin
			$display("%0t mismatch %s: exp st=%0d fi=%0d slot=%h kind=%0d tag=%h occ=%0d",
				$time, what, e.status, e.found_index, e.slot_us, e.out_kind, e.out_tag,
				e.occupancy);
			$display("    got st=%0d fi=%0d slot=%h kind=%0d tag=%h occ=%0d",
				a.status, a.found_index, a.slot_us, a.out_kind, a.out_tag, a.occupancy);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		in_word_t  w;
		out_word_t e, a;
		if (!arst_n) begin
			start_dly = RST_START_DELAY; margin = RST_MARGIN; prog_dly = RST_PROG_DELAY;
			max_adv = RST_MAX_ADVANCE; bcn_guard = RST_BCN_GUARD; bcn_rsv = RST_BCN_RESERVE;
			rows = 0;
			due_words.delete();
			fail_cnt = 0;
			pending <= 0; word_cnt <= 0; ok_cnt <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_START_DELAY: start_dly = cfg.data;
					CFG_MARGIN:      margin    = cfg.data;
					CFG_PROG_DELAY:  prog_dly  = cfg.data;
					CFG_MAX_ADVANCE: max_adv   = cfg.data;
					CFG_BCN_GUARD:   bcn_guard = cfg.data;
					CFG_BCN_RESERVE: bcn_rsv   = cfg.data;
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				w.func = req.func; w.now_us = req.now_us; w.pkt_kind = req.pkt_kind;
				w.target_us = req.target_us; w.air_time_ms = req.air_time_ms;
				w.packet_tag = req.packet_tag; w.entry_index = req.entry_index;
				due_words.push_back(predict(w));
			end
			if (rsp.valid && rsp.ready) begin
				a.status = rsp.status; a.found_index = rsp.found_index; a.slot_us = rsp.slot_us;
				a.out_kind = rsp.out_kind; a.out_tag = rsp.out_tag; a.occupancy = rsp.occupancy;
				word_cnt <= word_cnt + 1;
				if (due_words.size() == 0)
					complain("unexpected word", '0, a);
				else begin
					e = due_words.pop_front();
					if (e.status == ST_OK)
						ok_cnt <= ok_cnt + 1;
					if (e.status != a.status) complain("status", e, a);
					else if (e.found_index != a.found_index) complain("found_index", e, a);
					else if (e.slot_us != a.slot_us) complain("slot_us", e, a);
					else if (e.out_kind != a.out_kind) complain("out_kind", e, a);
					else if (e.out_tag != a.out_tag) complain("out_tag", e, a);
					else if (e.occupancy != a.occupancy) complain("occupancy", e, a);
				end
			end
			pending <= due_words.size();
		end
	end
endmodule
`default_nettype wire

[test/tb_top.sv]
// Stimulus, pacing and verdict for the transmit schedule queue.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import jtq_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	int   fail_cnt, pending, word_cnt, ok_cnt;

	jtq_in_if  req();
	jtq_out_if rsp();
	jtq_cfg_if cfg();

	jit_tx_schedule_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	jtq_sched_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg      (cfg),
		.fail_cnt (fail_cnt),
		.pending  (pending),
		.word_cnt (word_cnt),
		.ok_cnt   (ok_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// concentrator time as the stimulus sees it; wraps like the real counter
	us_t t_now;
	int  burst_left;
	int  sent;
	int  phases;
	// long receiver hold is requested by bumping hold_req
	int  hold_req, hold_seen, hold_left, mode_left;
	bit  calm;
	int  cycles;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: alternates calm stretches with random stalls, plus the odd long hold
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			mode_left = $urandom_range(16, 120);
			calm = ($urandom_range(0, 2) == 0);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else
			rsp.ready <= calm ? 1'b1 : ($urandom_range(0, 9) < 6);
	end

	// one request word; bursts of random length with random gaps between them
	task automatic send_word(input in_word_t w);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.func <= w.func; req.now_us <= w.now_us; req.pkt_kind <= w.pkt_kind;
		req.target_us <= w.target_us; req.air_time_ms <= w.air_time_ms;
		req.packet_tag <= w.packet_tag; req.entry_index <= w.entry_index;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	// the packet tag always gets a random value, also where the operation ignores it
	task automatic op(input func_t f, input kind_t k, input us_t tgt,
			input logic [15:0] air, input logic [4:0] idx);
		in_word_t w;
		w.func = f; w.now_us = t_now; w.pkt_kind = k; w.target_us = tgt;
		w.air_time_ms = air; w.packet_tag = 16'($urandom_range(0, 65535));
		w.entry_index = idx;
		send_word(w);
	endtask

	// sender stops and waits for every outstanding word to come back
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		burst_left = 0;
		wait (pending == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input us_t val);
		@(negedge clk);
		cfg.index <= idx;
		cfg.data <= val;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_timing(input us_t sd, input us_t mg, input us_t pd, input us_t ma,
			input us_t bg, input us_t br);
		drain();
		write_reg(CFG_START_DELAY, sd);
		write_reg(CFG_MARGIN, mg);
		write_reg(CFG_PROG_DELAY, pd);
		write_reg(CFG_MAX_ADVANCE, ma);
		write_reg(CFG_BCN_GUARD, bg);
		write_reg(CFG_BCN_RESERVE, br);
		phases++;
	endtask

	// well spaced class A/B packets, enough to reach a full table
	task automatic fill_table();
		int j;
		for (j = 0; j < 36; j++) begin
			t_now += 10;
			op(FN_ENQ, kind_t'($urandom_range(0, 1)),
				t_now + 100000 + j * 2500000 + $urandom_range(0, 1000),
				16'($urandom_range(0, 100)), 5'($urandom_range(0, 31)));
		end
	endtask

	task automatic random_word();
		int r;
		us_t tgt;
		logic [15:0] air;
		t_now += $urandom_range(0, 150000);
		if ($urandom_range(0, 19) == 0)
			t_now += $urandom_range(0, 30000000);
		r = $urandom_range(0, 99);
		if (r < 50) begin
			tgt = ($urandom_range(0, 99) < 85) ? t_now + $urandom_range(0, 25000000) : $urandom;
			air = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 400));
			op(FN_ENQ, kind_t'($urandom_range(0, 3)), tgt, air, 5'($urandom_range(0, 31)));
		end else if (r < 70)
			op(FN_DEQ, kind_t'($urandom_range(0, 3)), $urandom,
				16'($urandom_range(0, 65535)),
				($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 5))
					: 5'($urandom_range(0, 31)));
		else if (r < 95)
			op(FN_PEEK, kind_t'($urandom_range(0, 3)), $urandom,
				16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
		else
			op(FN_BAD, kind_t'($urandom_range(0, 3)), $urandom,
				16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
	endtask

	task automatic random_part(input int n, input bit with_hold);
		int i;
		for (i = 0; i < n; i++) begin
			// receiver sits still while words keep coming, so the block backs up
			if (with_hold && i == n / 3)
				hold_req++;
			// mid-phase pause until the queue has answered everything
			if (i == (2 * n) / 3)
				drain();
			random_word();
		end
	endtask

	initial begin
		// every input known from time zero
		req.valid = 1'b0; req.func = FN_PEEK; req.now_us = '0; req.pkt_kind = KIND_A;
		req.target_us = '0; req.air_time_ms = '0; req.packet_tag = '0; req.entry_index = '0;
		cfg.valid = 1'b0; cfg.index = CFG_START_DELAY; cfg.data = '0;
		rsp.ready = 1'b0;
		hold_req = 0; hold_seen = 0; hold_left = 0; mode_left = 0; calm = 1'b1;
		burst_left = 0; sent = 0; phases = 0; cycles = 0;
		t_now = $urandom;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed opening on an empty table, default timing
		op(FN_PEEK, KIND_A, '0, '0, '0);                          // peek, empty
		op(FN_DEQ, KIND_A, '0, '0, 5'd0);                         // dequeue, empty
		op(FN_DEQ, KIND_BCN, '1, '1, 5'd31);                      // top index, empty
		op(FN_BAD, KIND_C, '1, '1, 5'd31);                        // unknown operation
		op(FN_ENQ, KIND_A, t_now + 1000, 16'd10, '0);             // too late
		op(FN_ENQ, KIND_B, t_now + 600000000, 16'd10, '0);        // too early
		op(FN_ENQ, KIND_A, t_now + 5000000, 16'd50, '0);          // accepted
		op(FN_ENQ, KIND_B, t_now + 5000100, 16'd5, '0);           // packet collision
		op(FN_ENQ, KIND_BCN, t_now + 20000000, 16'd0, '0);        // beacon
		op(FN_ENQ, KIND_A, t_now + 20000500, 16'd0, '0);          // beacon collision
		op(FN_ENQ, KIND_C, '1, 16'd100, '0);                      // class C, nominal slot
		op(FN_ENQ, KIND_C, '0, 16'd100, '0);                      // class C, pushed back
		op(FN_ENQ, KIND_B, t_now + 9000000, 16'hFFFF, '1);        // longest air time
		op(FN_PEEK, KIND_A, '0, '0, '0);                          // not yet due
		op(FN_DEQ, KIND_A, '0, '0, 5'd20);                        // index past occupancy
		op(FN_DEQ, KIND_A, '0, '0, 5'd1);                         // remove from the middle
		t_now += 4990000;
		op(FN_PEEK, KIND_A, '0, '0, '0);                          // due now
		t_now += 200000000;
		op(FN_PEEK, KIND_A, '0, '0, '0);                          // everything stale
		op(FN_ENQ, KIND_A, '0 - 32'd1, 16'd0, '0);                // wrap of timestamp

		random_part(120, 1'b1);
		fill_table();                                             // drives table full

		// low extremes, then high extremes, then random, then tight, then reset values
		set_timing('0, '0, '0, '1, '0, '0);
		fill_table();
		random_part(120, 1'b0);
		set_timing('1, '1, '1, '1, '1, '1);
		fill_table();
		random_part(120, 1'b0);
		set_timing($urandom_range(0, 5000), $urandom_range(0, 5000), $urandom_range(0, 200000),
			$urandom, $urandom_range(0, 4000000), $urandom_range(0, 3000000));
		fill_table();
		random_part(120, 1'b1);
		set_timing(32'd100, 32'd50, 32'd10000, 32'd50000000, 32'd200000, 32'd100000);
		fill_table();
		random_part(120, 1'b0);
		set_timing(RST_START_DELAY, RST_MARGIN, RST_PROG_DELAY, RST_MAX_ADVANCE,
			RST_BCN_GUARD, RST_BCN_RESERVE);
		fill_table();
		random_part(120, 1'b0);

		drain();
		repeat (40) @(posedge clk);
		$display("covered %0d request words over %0d timing settings plus reset values",
			sent, phases);
		$display("%0d result words checked, %0d of them ok, %0d mismatches",
			word_cnt, ok_cnt, fail_cnt);
		if (fail_cnt == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
